FILE: src/acs_pkg.sv
// Shared types, constants and helper functions for the actuator cycle sequencer.
package acs_pkg;

  localparam int unsigned TimerWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned PressWidth = 3;
  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned DataWidth  = 32;

  typedef logic [TimerWidth-1:0] timer_t;
  typedef logic [CfgWidth-1:0]   cfg_ticks_t;
  typedef logic [PressWidth-1:0] press_t;

  typedef enum logic [2:0] {
    PhExtend    = 3'd0,
    PhHoldZero  = 3'd1,
    PhRetract   = 3'd2,
    PhHoldSpeed = 3'd3,
    PhIdle      = 3'd4,
    PhPush      = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    PinsBrake   = 2'd0,
    PinsExtend  = 2'd1,
    PinsRetract = 2'd2,
    PinsStop    = 2'd3
  } pins_e;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpSpeed = 2'd1,
    OpEstop = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    RegRetractSlow = 3'd0,
    RegRetractMid  = 3'd1,
    RegRetractFast = 3'd2,
    RegHoldSlow    = 3'd3,
    RegHoldMid     = 3'd4,
    RegHoldFast    = 3'd5,
    RegPresses     = 3'd6
  } reg_idx_e;

  localparam cfg_ticks_t RetractSlowRst = 16'd3600;
  localparam cfg_ticks_t RetractMidRst  = 16'd5600;
  localparam cfg_ticks_t RetractFastRst = 16'd13000;
  localparam cfg_ticks_t HoldSlowRst    = 16'd3000;
  localparam cfg_ticks_t HoldMidRst     = 16'd8000;
  localparam cfg_ticks_t HoldFastRst    = 16'd10000;
  localparam press_t     PressesRst     = 3'd2;

  localparam cfg_ticks_t HoldZeroSlow = 16'd4800;
  localparam cfg_ticks_t HoldZeroMid  = 16'd12000;
  localparam cfg_ticks_t HoldZeroFast = 16'd5000;

  typedef struct packed {
    cfg_ticks_t retract_slow;
    cfg_ticks_t retract_mid;
    cfg_ticks_t retract_fast;
    cfg_ticks_t hold_slow;
    cfg_ticks_t hold_mid;
    cfg_ticks_t hold_fast;
    press_t     presses_needed;
  } cfg_t;

  typedef struct packed {
    pins_e        pins;
    phase_e       phase;
    logic [1:0]   speed;
    logic         listening;
  } result_t;

  // Saturate a 16-bit duration into the timer width.
  function automatic timer_t sat_load(input cfg_ticks_t d);
    logic [63:0] d64;
    logic [63:0] lim;
    d64 = 64'(d);
    lim = (64'd1 << TimerWidth) - 64'd1;
    return timer_t'((d64 > lim) ? lim : d64);
  endfunction

  function automatic cfg_ticks_t pick(input logic [1:0] sel, input cfg_ticks_t s,
                                      input cfg_ticks_t m, input cfg_ticks_t f);
    unique case (sel)
      2'd0:    return s;
      2'd1:    return m;
      default: return f;
    endcase
  endfunction

endpackage

FILE: src/acs_cfg.sv
// APB register file holding the sequencer durations and press threshold.
module acs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acs_pkg::AddrWidth-1:0] paddr,
  input  logic [acs_pkg::DataWidth-1:0] pwdata,
  output logic [acs_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output acs_pkg::cfg_t                 cfg_o
);
  import acs_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retract_slow   <= RetractSlowRst;
      cfg_q.retract_mid    <= RetractMidRst;
      cfg_q.retract_fast   <= RetractFastRst;
      cfg_q.hold_slow      <= HoldSlowRst;
      cfg_q.hold_mid       <= HoldMidRst;
      cfg_q.hold_fast      <= HoldFastRst;
      cfg_q.presses_needed <= PressesRst;
    end else if (wr_en) begin
      unique case (idx)
        RegRetractSlow: cfg_q.retract_slow   <= pwdata[CfgWidth-1:0];
        RegRetractMid:  cfg_q.retract_mid    <= pwdata[CfgWidth-1:0];
        RegRetractFast: cfg_q.retract_fast   <= pwdata[CfgWidth-1:0];
        RegHoldSlow:    cfg_q.hold_slow      <= pwdata[CfgWidth-1:0];
        RegHoldMid:     cfg_q.hold_mid       <= pwdata[CfgWidth-1:0];
        RegHoldFast:    cfg_q.hold_fast      <= pwdata[CfgWidth-1:0];
        RegPresses:     cfg_q.presses_needed <= pwdata[PressWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegRetractSlow: prdata = DataWidth'(cfg_q.retract_slow);
      RegRetractMid:  prdata = DataWidth'(cfg_q.retract_mid);
      RegRetractFast: prdata = DataWidth'(cfg_q.retract_fast);
      RegHoldSlow:    prdata = DataWidth'(cfg_q.hold_slow);
      RegHoldMid:     prdata = DataWidth'(cfg_q.hold_mid);
      RegHoldFast:    prdata = DataWidth'(cfg_q.hold_fast);
      RegPresses:     prdata = DataWidth'(cfg_q.presses_needed);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/acs_core.sv
// Sequencer state and next-state logic for one request per cycle while en_i is high.
module acs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [1:0]        op_i,
  input  logic              sw_i,
  input  logic              pwr_i,
  input  acs_pkg::cfg_t     cfg_i,
  output acs_pkg::result_t  res_o
);
  import acs_pkg::*;

  phase_e     phase_q, phase_d;
  phase_e     resume_q, resume_d;
  timer_t     timer_q, timer_d;
  logic       run_q, run_d;
  logic [1:0] speed_q, speed_d;
  press_t     press_q, press_d;
  logic       listen_q, listen_d;
  pins_e      pins_q, pins_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhExtend;
      resume_q <= PhExtend;
      timer_q  <= '0;
      run_q    <= 1'b0;
      speed_q  <= '0;
      press_q  <= '0;
      listen_q <= 1'b0;
      pins_q   <= PinsExtend;
    end else if (en_i) begin
      phase_q  <= phase_d;
      resume_q <= resume_d;
      timer_q  <= timer_d;
      run_q    <= run_d;
      speed_q  <= speed_d;
      press_q  <= press_d;
      listen_q <= listen_d;
      pins_q   <= pins_d;
    end
  end

  always_comb begin
    press_t need;
    press_t press_inc;
    timer_t t_dec;
    logic   push_req;

    phase_d  = phase_q;
    resume_d = resume_q;
    timer_d  = timer_q;
    run_d    = run_q;
    speed_d  = speed_q;
    press_d  = press_q;
    listen_d = listen_q;
    pins_d   = pins_q;

    need      = (cfg_i.presses_needed == '0) ? press_t'(1) : cfg_i.presses_needed;
    press_inc = press_q + press_t'(1);
    t_dec     = (timer_q != '0) ? timer_q - timer_t'(1) : timer_q;
    push_req  = 1'b0;

    unique case (op_i)
      OpTick: begin
        if (phase_q == PhPush) begin
          // timers stay frozen while pushing
          if (sw_i) begin
            pins_d  = PinsBrake;
            phase_d = resume_q;
          end
        end else if (phase_q == PhExtend) begin
          if (sw_i) begin
            press_d = press_inc;
            if (press_inc >= need) begin
              press_d = '0;
              pins_d  = PinsStop;
              phase_d = PhHoldZero;
              timer_d = sat_load(pick(speed_q, HoldZeroSlow, HoldZeroMid, HoldZeroFast));
              run_d   = 1'b1;
            end
          end
        end else if (run_q) begin
          timer_d = t_dec;
          if (t_dec == '0) begin
            run_d = 1'b0;
            unique case (phase_q)
              PhHoldZero: begin
                if (pwr_i) begin
                  listen_d = 1'b0;
                  pins_d   = PinsRetract;
                  phase_d  = PhRetract;
                  timer_d  = sat_load(pick(speed_q, cfg_i.retract_slow,
                                           cfg_i.retract_mid, cfg_i.retract_fast));
                  run_d    = 1'b1;
                end else begin
                  phase_d = PhIdle;
                end
              end
              PhRetract: begin
                listen_d = 1'b1;
                pins_d   = PinsStop;
                phase_d  = PhHoldSpeed;
                timer_d  = sat_load(pick(speed_q, cfg_i.hold_slow,
                                         cfg_i.hold_mid, cfg_i.hold_fast));
                run_d    = 1'b1;
              end
              PhHoldSpeed: begin
                pins_d  = PinsExtend;
                phase_d = PhExtend;
              end
              default: ;
            endcase
          end
        end
      end
      OpSpeed: begin
        push_req = listen_q;
        speed_d  = (speed_q < 2'd2) ? speed_q + 2'd1 : 2'd0;
      end
      OpEstop: begin
        push_req = !pwr_i;
      end
      default: ;
    endcase

    // drive out to the switch, or brake at once if already there
    if (push_req && phase_q != PhPush) begin
      if (sw_i) begin
        pins_d = PinsBrake;
      end else begin
        resume_d = phase_q;
        phase_d  = PhPush;
        pins_d   = PinsExtend;
      end
    end
  end

  assign res_o.pins      = pins_d;
  assign res_o.phase     = phase_d;
  assign res_o.speed     = speed_d;
  assign res_o.listening = listen_d;

  a_resume_not_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resume_q != PhPush) else $error("push return phase is push");

  a_timer_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (phase_q != PhExtend && phase_q != PhIdle))
    else $error("timer running in an untimed phase");

  a_retract_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhRetract |-> !listen_q) else $error("listening while retracting");

  a_push_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPush |-> pins_q == PinsExtend) else $error("push without extend pins");

endmodule

FILE: src/actuator_cycle_sequencer.sv
// Actuator cycle sequencer: input register, next-state core, result register.
// A request is held in the input register; the core's result for it is then held in the result register.
// Throughput: one request per cycle when not stalled; the result register frees the input side.
// The input stage advances whenever the result register is empty or being taken.
// Reset (rst_ni low, asynchronous) clears both stages, extends the actuator and
// restores the register defaults.
module actuator_cycle_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // switch_pressed, power_on, zero pad
  input  logic [1:0]                    s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // drive_a, drive_b, phase, speed_index, listening
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acs_pkg::AddrWidth-1:0] paddr,
  input  logic [acs_pkg::DataWidth-1:0] pwdata,
  output logic [acs_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import acs_pkg::*;

  cfg_t       cfg;
  result_t    res;
  result_t    out_q;
  logic       in_vld_q, out_vld_q;
  logic [1:0] op_q;
  logic       sw_q, pwr_q;
  logic       advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q  <= s_axis_tuser;
      sw_q  <= s_axis_tdata[0];
      pwr_q <= s_axis_tdata[1];
    end
    if (advance) out_q <= res;
  end

  acs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  acs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .op_i   (op_q),
    .sw_i   (sw_q),
    .pwr_i  (pwr_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.listening, out_q.speed, out_q.phase,
                          out_q.pins[0], out_q.pins[1]};

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the actuator cycle sequencer: streamed requests, predicted results.
`timescale 1ns / 100ps
module testbench;
  import acs_pkg::*;

  localparam logic [1:0]  OpReserved = 2'd3;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned IdlePct    = 29;
  localparam int unsigned ReportMax  = 30;

  typedef struct packed {
    logic [1:0] op;
    logic       sw;
    logic       pwr;
    logic       burst;  // timer run-down request, streamed without gaps
  } seq_req_t;

  typedef struct {
    phase_e     phase;
    phase_e     resume;
    pins_e      pins;
    timer_t     timer;
    logic       running;
    logic [1:0] speed;
    press_t     presses;
    logic       listen;
  } seq_state_t;

  typedef struct packed {
    logic       drive_a;
    logic       drive_b;
    phase_e     phase;
    logic [1:0] speed;
    logic       listen;
    logic       burst;
  } seq_out_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // switch_pressed, power_on, zero pad
  logic [1:0]           s_axis_tuser  = '0;  // opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // drive_a, drive_b, phase, speed_index, listening
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [AddrWidth-1:0] paddr         = '0;
  logic [DataWidth-1:0] pwdata        = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  // shadow of the timing registers
  cfg_ticks_t retract_ticks [3];
  cfg_ticks_t hold_ticks [3];
  press_t     presses_needed;

  seq_state_t live;  // advanced on accepted requests
  seq_state_t plan;  // advanced as requests are queued
  seq_req_t   on_bus;
  seq_req_t   pending_requests [$];
  seq_out_t   expected_outputs [$];

  int unsigned error_count    = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count  = 0;
  int unsigned write_count    = 0;
  int unsigned cycle_count    = 0;

  actuator_cycle_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic seq_state_t powered_up_state();
    seq_state_t st;
    st.phase   = PhExtend;
    st.resume  = PhExtend;
    st.pins    = PinsExtend;
    st.timer   = '0;
    st.running = 1'b0;
    st.speed   = '0;
    st.presses = '0;
    st.listen  = 1'b0;
    return st;
  endfunction

  function automatic void request_push(inout seq_state_t st, input logic sw);
    if (st.phase != PhPush) begin
      if (sw) begin
        st.pins = PinsBrake;
      end else begin
        st.resume = st.phase;
        st.phase  = PhPush;
        st.pins   = PinsExtend;
      end
    end
  endfunction

  function automatic void sequencer_step(inout seq_state_t st, input seq_req_t rq);
    logic [1:0] idx;
    press_t     need;
    idx  = (st.speed > 2'd2) ? 2'd2 : st.speed;
    need = (presses_needed == '0) ? press_t'(1) : presses_needed;
    case (rq.op)
      OpTick: begin
        if (st.phase == PhPush) begin
          // timers stay frozen until the switch is reached
          if (rq.sw) begin
            st.pins  = PinsBrake;
            st.phase = st.resume;
          end
        end else if (st.phase == PhExtend) begin
          if (rq.sw) begin
            st.presses = st.presses + 1'b1;
            if (st.presses >= need) begin
              st.presses = '0;
              st.pins    = PinsStop;
              st.phase   = PhHoldZero;
              st.timer   = (idx == 2'd0) ? HoldZeroSlow :
                           (idx == 2'd1) ? HoldZeroMid : HoldZeroFast;
              st.running = 1'b1;
            end
          end
        end else if (st.running) begin
          if (st.timer != '0) st.timer = st.timer - 1'b1;
          if (st.timer == '0) begin
            st.running = 1'b0;
            case (st.phase)
              PhHoldZero: begin
                if (rq.pwr) begin
                  st.listen  = 1'b0;
                  st.pins    = PinsRetract;
                  st.phase   = PhRetract;
                  st.timer   = retract_ticks[idx];
                  st.running = 1'b1;
                end else begin
                  st.phase = PhIdle;
                end
              end
              PhRetract: begin
                st.listen  = 1'b1;
                st.pins    = PinsStop;
                st.phase   = PhHoldSpeed;
                st.timer   = hold_ticks[idx];
                st.running = 1'b1;
              end
              PhHoldSpeed: begin
                st.pins  = PinsExtend;
                st.phase = PhExtend;
              end
              default: ;
            endcase
          end
        end
      end
      OpSpeed: begin
        if (st.listen) request_push(st, rq.sw);
        st.speed = (st.speed < 2'd2) ? st.speed + 1'b1 : 2'd0;
      end
      OpEstop: begin
        if (!rq.pwr) request_push(st, rq.sw);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
    error_count++;
    if (error_count <= ReportMax) $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  task automatic send(input logic [1:0] op, input logic sw, input logic pwr, input logic burst);
    seq_req_t rq;
    rq = '{op: op, sw: sw, pwr: pwr, burst: burst};
    sequencer_step(plan, rq);
    pending_requests.push_back(rq);
  endtask

  // Tick a running timer down until at most keep ticks are left.
  task automatic run_down(input int unsigned keep);
    while ((plan.phase == PhHoldZero || plan.phase == PhRetract || plan.phase == PhHoldSpeed)
           && plan.running && plan.timer > keep)
      send(OpTick, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic random_request(input logic may_stop);
    int unsigned roll;
    logic [1:0]  op;
    logic        sw;
    logic        pwr;
    roll = $urandom_range(99);
    sw   = ($urandom_range(99) < 35);
    pwr  = 1'($urandom_range(1));
    if (roll < 68) op = OpTick;
    else if (roll < 84) op = OpSpeed;
    else if (roll < 96) op = OpEstop;
    else op = OpReserved;
    // keep power on when hold zero is about to run out, else the cycle ends idle
    if (!may_stop && plan.phase == PhHoldZero && plan.running && plan.timer <= 1) pwr = 1'b1;
    send(op, sw, pwr, 1'b0);
  endtask

  task automatic random_phase(input int unsigned count, input logic may_stop);
    repeat (count) begin
      run_down(3);
      random_request(may_stop);
    end
  endtask

  // Wait until every request is taken and every result has come back.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    logic [DataWidth-1:0] word;
    word = {16'($urandom), value};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegRetractSlow: retract_ticks[0] = value;
      RegRetractMid:  retract_ticks[1] = value;
      RegRetractFast: retract_ticks[2] = value;
      RegHoldSlow:    hold_ticks[0] = value;
      RegHoldMid:     hold_ticks[1] = value;
      RegHoldFast:    hold_ticks[2] = value;
      RegPresses:     presses_needed = value[2:0];
      default: ;
    endcase
    write_count++;
  endtask

  task automatic program_timing(input cfg_ticks_t r_slow, input cfg_ticks_t r_mid,
                                input cfg_ticks_t r_fast, input cfg_ticks_t h_slow,
                                input cfg_ticks_t h_mid, input cfg_ticks_t h_fast,
                                input press_t need);
    write_reg(RegRetractSlow, r_slow);
    write_reg(RegRetractMid, r_mid);
    write_reg(RegRetractFast, r_fast);
    write_reg(RegHoldSlow, h_slow);
    write_reg(RegHoldMid, h_mid);
    write_reg(RegHoldFast, h_fast);
    write_reg(RegPresses, {13'($urandom), need});
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_requests
    seq_req_t nxt;
    seq_out_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sequencer_step(live, on_bus);
        want.drive_a = live.pins[1];
        want.drive_b = live.pins[0];
        want.phase   = live.phase;
        want.speed   = live.speed;
        want.listen  = live.listen;
        want.burst   = on_bus.burst;
        expected_outputs.push_back(want);
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 &&
            (pending_requests[0].burst || $urandom_range(99) >= IdlePct)) begin
          nxt = pending_requests.pop_front();
          on_bus = nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, nxt.pwr, nxt.sw};
          s_axis_tuser  <= nxt.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    seq_out_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked_count++;
        if (expected_outputs.size() == 0) begin
          note_mismatch("unexpected result", 0, m_axis_tdata);
        end else begin
          want = expected_outputs.pop_front();
          if (m_axis_tdata[0] !== want.drive_a)
            note_mismatch("drive_a", want.drive_a, m_axis_tdata[0]);
          if (m_axis_tdata[1] !== want.drive_b)
            note_mismatch("drive_b", want.drive_b, m_axis_tdata[1]);
          if (m_axis_tdata[4:2] !== want.phase)
            note_mismatch("phase", want.phase, m_axis_tdata[4:2]);
          if (m_axis_tdata[6:5] !== want.speed)
            note_mismatch("speed_index", want.speed, m_axis_tdata[6:5]);
          if (m_axis_tdata[7] !== want.listen)
            note_mismatch("listening", want.listen, m_axis_tdata[7]);
        end
      end
      // no stalls while a timer run-down streams through
      m_axis_tready <= (expected_outputs.size() != 0 && expected_outputs[0].burst) ||
                       ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    live = powered_up_state();
    plan = powered_up_state();
    retract_ticks  = '{RetractSlowRst, RetractMidRst, RetractFastRst};
    hold_ticks     = '{HoldSlowRst, HoldMidRst, HoldFastRst};
    presses_needed = PressesRst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: events in every phase but idle, pushes, zero-length retract
    program_timing(16'd0, 16'd1, 16'd2, 16'd2, 16'd0, 16'd1, 3'd2);
    send(OpTick, 1'b0, 1'b0, 1'b0);
    send(OpSpeed, 1'b0, 1'b1, 1'b0);      // not listening: speed only
    send(OpEstop, 1'b0, 1'b1, 1'b0);      // power on: ignored
    send(OpEstop, 1'b0, 1'b0, 1'b0);      // push out from extend
    send(OpSpeed, 1'b0, 1'b0, 1'b0);      // during push: speed still steps
    send(OpEstop, 1'b0, 1'b0, 1'b0);
    send(OpTick, 1'b0, 1'b0, 1'b0);
    send(OpTick, 1'b1, 1'b0, 1'b0);       // switch reached: brake, press not counted
    send(OpEstop, 1'b1, 1'b0, 1'b0);      // already pressed: brake at once
    send(OpReserved, 1'b1, 1'b1, 1'b0);
    send(OpSpeed, 1'b0, 1'b0, 1'b0);
    send(OpTick, 1'b1, 1'b1, 1'b0);
    send(OpTick, 1'b1, 1'b1, 1'b0);       // enough presses: hold zero
    run_down(1);
    send(OpTick, 1'b0, 1'b1, 1'b0);       // retract with zero duration
    send(OpTick, 1'b0, 1'b0, 1'b0);       // expires on the next tick
    send(OpSpeed, 1'b0, 1'b0, 1'b0);      // listening: push from hold speed
    send(OpTick, 1'b0, 1'b0, 1'b0);
    send(OpTick, 1'b1, 1'b0, 1'b0);
    send(OpTick, 1'b0, 1'b0, 1'b0);
    send(OpTick, 1'b0, 1'b0, 1'b0);
    send(OpSpeed, 1'b1, 1'b0, 1'b0);
    settle();

    program_timing(cfg_ticks_t'($urandom_range(5)), cfg_ticks_t'($urandom_range(5)),
                   cfg_ticks_t'($urandom_range(5)), cfg_ticks_t'($urandom_range(5)),
                   cfg_ticks_t'($urandom_range(5)), cfg_ticks_t'($urandom_range(5)),
                   press_t'($urandom_range(3, 1)));
    random_phase(150, 1'b0);
    settle();

    program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 3'd7);
    random_phase(130, 1'b0);
    settle();

    // longest durations, and a zero press count that acts as one
    program_timing(16'hFFFF, 16'd3, 16'd1, 16'd2, 16'hFFFF, 16'd0, 3'd0);
    random_phase(40, 1'b0);
    settle();

    // closing: let hold zero run out with power off, then work the idle state
    program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 3'd1);
    while (plan.phase != PhHoldZero) begin
      run_down(1);
      send(OpTick, 1'b1, 1'b1, 1'b0);
    end
    run_down(1);
    send(OpTick, 1'b0, 1'b0, 1'b0);
    send(OpTick, 1'b1, 1'b1, 1'b0);
    send(OpSpeed, 1'b0, 1'b1, 1'b0);
    send(OpTick, 1'b0, 1'b1, 1'b0);
    send(OpTick, 1'b1, 1'b1, 1'b0);
    send(OpEstop, 1'b0, 1'b0, 1'b0);
    send(OpEstop, 1'b0, 1'b0, 1'b0);
    send(OpTick, 1'b1, 1'b0, 1'b0);
    send(OpEstop, 1'b1, 1'b0, 1'b0);
    send(OpReserved, 1'b0, 1'b0, 1'b0);
    random_phase(60, 1'b1);
    settle();

    $display("Run covered %0d requests and %0d results across %0d register writes,",
             accepted_count, checked_count, write_count);
    $display("with pushes, the idle stop, the reserved opcode and timers up to 65535 ticks.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
